// ===== src/aocs_pkg.sv =====
`timescale 1ns / 1ps
// aocs_pkg: opcodes, status codes, default sizes and shared types of the
// A* open/closed store. No dependencies.
package aocs_pkg;

	localparam int OPEN_SLOTS_DEF = 256;
	localparam int NODE_COUNT_DEF = 4096;

	localparam int ID_W   = 12;
	localparam int COST_W = 32;
	localparam int AGE_W  = 32;

	typedef enum logic [2:0] {
		OP_ADD_OPEN   = 3'd0,
		OP_ADD_CLOSED = 3'd1,
		OP_REM_OPEN   = 3'd2,
		OP_REM_CLOSED = 3'd3,
		OP_POP        = 3'd4,
		OP_FIND_OPEN  = 3'd5,
		OP_FIND_CLOSED = 3'd6,
		OP_CLEAR      = 3'd7
	} opcode_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_IGNORED  = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_INLIST   = 3'd4;

	localparam logic [1:0] MEM_NONE   = 2'd0;
	localparam logic [1:0] MEM_OPEN   = 2'd1;
	localparam logic [1:0] MEM_CLOSED = 2'd2;

	localparam logic [1:0] FLAG_NONE   = 2'd0;
	localparam logic [1:0] FLAG_OPEN   = 2'd1;
	localparam logic [1:0] FLAG_CLOSED = 2'd2;

	typedef struct packed {
		logic              have;
		logic [ID_W-1:0]   node;
		logic [COST_W-1:0] cost;
		logic [AGE_W-1:0]  age;
	} best_t;

endpackage

// ===== src/aocs_best_sel.sv =====
`timescale 1ns / 1ps
// aocs_best_sel: running minimum over a slot scan, cheapest cost first,
// most recent age on a tie. Depends on aocs_pkg.
module aocs_best_sel #(
	parameter int SW = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      en,
	input  logic                      slot_v,
	input  logic [aocs_pkg::ID_W-1:0]   node,
	input  logic [aocs_pkg::COST_W-1:0] cost,
	input  logic [aocs_pkg::AGE_W-1:0]  age,
	input  logic [SW-1:0]             idx,
	output aocs_pkg::best_t           best,
	output logic [SW-1:0]             best_idx
);

	logic                       have_q;
	logic [aocs_pkg::ID_W-1:0]   node_q;
	logic [aocs_pkg::COST_W-1:0] cost_q;
	logic [aocs_pkg::AGE_W-1:0]  age_q;
	logic [SW-1:0]         idx_q;
	logic [aocs_pkg::AGE_W-1:0] age_d;
	logic                  newer;
	logic                  take;

	assign age_d = age - age_q;
	assign newer = (age_d != '0) && !age_d[aocs_pkg::AGE_W-1];
	assign take  = en && slot_v && (!have_q || cost < cost_q ||
		(cost == cost_q && newer));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (start) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			node_q <= node;
			cost_q <= cost;
			age_q  <= age;
			idx_q  <= idx;
		end
	end

	assign best     = {have_q, node_q, cost_q, age_q};
	assign best_idx = idx_q;

endmodule

// ===== src/astar_open_closed_store_unit.sv =====
`timescale 1ns / 1ps
// astar_open_closed_store_unit: open and closed sets of an A* search.
// Depends on aocs_pkg and aocs_best_sel.
//
// Usage: one request on the s_ channel (tuser = opcode, tdata = node id and
// Q16.16 cost) gives exactly one result on the m_ channel (tuser = found,
// tdata = status, node, cost). One request is worked on at a time.
// Add open searches the slots upward from slot 0 for the lowest free one.
// Pop cheapest scans all OPEN_SLOTS slots, one slot read per cycle from the
// slot memory. Clear writes every node entry, one per cycle.
// s_tready rises as the result is loaded into the output register, so a new
// request is taken only after the last result has been loaded.
// After reset the node memory is swept to zero, and s_tready stays low
// during that pass. The result sits in an output register; if the receiver
// stalls, the block finishes the next request and holds it until the
// register frees up.
module astar_open_closed_store_unit #(
	parameter int OPEN_SLOTS = aocs_pkg::OPEN_SLOTS_DEF,
	parameter int NODE_COUNT = aocs_pkg::NODE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [11:0] node_id, [43:12] fitness_in, zero fill
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [2:0] status, [14:3] node_out, [46:15] fitness_out
	output logic        m_tuser    // [0] found
);

	localparam int SW = (OPEN_SLOTS > 1) ? $clog2(OPEN_SLOTS) : 1;
	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW = $clog2(OPEN_SLOTS + 1);
	localparam int IW = aocs_pkg::ID_W;
	localparam int KW = aocs_pkg::COST_W;
	localparam int AW = aocs_pkg::AGE_W;
	localparam int NMW = SW + 4;
	localparam int SMW = IW + KW + AW;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_NRD, S_FREE, S_SRD, S_SCAN, S_DRAIN,
		S_POPRD, S_POPWR, S_DONE
	} state_t;

	state_t state_q;

	logic [NMW-1:0] node_mem [NODE_COUNT];
	logic [SMW-1:0] slot_mem [OPEN_SLOTS];

	logic [OPEN_SLOTS-1:0] valid_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         age_q;
	logic [NW-1:0]         clr_q;
	logic                  clr_pend_q;
	logic [SW-1:0]         scan_q;

	aocs_pkg::opcode_t op_q;
	logic [IW-1:0]     id_q;
	logic [KW-1:0]     cost_q;

	logic [NMW-1:0] nrd_q;
	logic [SMW-1:0] srd_q;
	logic           nwe_q;
	logic [NW-1:0]  nwa_q;
	logic [NMW-1:0] nwd_q;
	logic           swe_q;
	logic [SW-1:0]  swa_q;
	logic [SMW-1:0] swd_q;

	logic           en_s1;
	logic           sv_s1;
	logic [SW-1:0]  sidx_s1;

	logic [2:0]     res_status_q;
	logic           res_found_q;
	logic [IW-1:0]  res_node_q;
	logic [KW-1:0]  res_fit_q;

	logic           out_valid_q;
	logic [2:0]     out_status_q;
	logic           out_found_q;
	logic [IW-1:0]  out_node_q;
	logic [KW-1:0]  out_fit_q;

	logic           nm_we;
	logic [NW-1:0]  nm_wa;
	logic [NMW-1:0] nm_wd;
	logic [NW-1:0]  nm_ra;
	logic [SW-1:0]  sm_ra;

	aocs_pkg::best_t best;
	logic [SW-1:0]   best_idx;

	logic [1:0]      n_flags;
	logic [1:0]      n_mem;
	logic [SW-1:0]   n_idx;
	logic            id_ok;
	logic            accept;

	assign n_flags = nrd_q[NMW-1 -: 2];
	assign n_mem   = nrd_q[SW+1 -: 2];
	assign n_idx   = nrd_q[SW-1:0];
	assign id_ok   = {5'd0, s_tdata[IW-1:0]} < 17'(NODE_COUNT);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign nm_we = nwe_q || (state_q == S_CLR);
	assign nm_wa = (state_q == S_CLR) ? clr_q : nwa_q;
	assign nm_wd = (state_q == S_CLR) ? '0 : nwd_q;
	assign nm_ra = (state_q == S_POPRD) ? NW'(best.node) : NW'(id_q);
	assign sm_ra = (state_q == S_SCAN) ? scan_q : n_idx;

	always_ff @(posedge clk) begin
		if (nm_we) begin
			node_mem[nm_wa] <= nm_wd;
		end
		nrd_q <= node_mem[nm_ra];
	end

	always_ff @(posedge clk) begin
		if (swe_q) begin
			slot_mem[swa_q] <= swd_q;
		end
		srd_q <= slot_mem[sm_ra];
	end

	aocs_best_sel #(.SW(SW)) u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.en       (en_s1),
		.slot_v   (sv_s1),
		.node     (srd_q[IW-1:0]),
		.cost     (srd_q[IW+KW-1:IW]),
		.age      (srd_q[SMW-1:IW+KW]),
		.idx      (sidx_s1),
		.best     (best),
		.best_idx (best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			valid_q      <= '0;
			count_q      <= '0;
			age_q        <= '0;
			clr_q        <= '0;
			clr_pend_q   <= 1'b0;
			scan_q       <= '0;
			nwe_q        <= 1'b0;
			swe_q        <= 1'b0;
			en_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			nwe_q <= 1'b0;
			swe_q <= 1'b0;
			en_s1 <= 1'b0;
			if (out_valid_q && m_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (clr_q == NW'(NODE_COUNT - 1)) begin
						clr_q   <= '0;
						state_q <= clr_pend_q ? S_DONE : S_IDLE;
					end else begin
						clr_q <= clr_q + NW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q         <= aocs_pkg::opcode_t'(s_tuser);
						id_q         <= s_tdata[IW-1:0];
						cost_q       <= s_tdata[IW+KW-1:IW];
						res_status_q <= aocs_pkg::ST_OK;
						res_found_q  <= 1'b0;
						res_node_q   <= '0;
						res_fit_q    <= '0;
						scan_q       <= '0;
						if (aocs_pkg::opcode_t'(s_tuser) == aocs_pkg::OP_POP) begin
							state_q <= S_SCAN;
						end else if (aocs_pkg::opcode_t'(s_tuser) == aocs_pkg::OP_CLEAR) begin
							valid_q    <= '0;
							count_q    <= '0;
							age_q      <= '0;
							clr_pend_q <= 1'b1;
							state_q    <= S_CLR;
						end else if (!id_ok) begin
							res_status_q <= aocs_pkg::ST_NOTFOUND;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_NRD;
				end
				S_NRD: begin
					nwa_q   <= NW'(id_q);
					state_q <= S_DONE;
					unique case (op_q)
						aocs_pkg::OP_ADD_OPEN: begin
							if (n_flags[0]) begin
								res_status_q <= aocs_pkg::ST_IGNORED;
							end else if (n_mem != aocs_pkg::MEM_NONE) begin
								res_status_q <= aocs_pkg::ST_INLIST;
							end else if (count_q == CW'(OPEN_SLOTS)) begin
								res_status_q <= aocs_pkg::ST_FULL;
							end else begin
								state_q <= S_FREE;
							end
						end
						aocs_pkg::OP_ADD_CLOSED: begin
							if (n_mem != aocs_pkg::MEM_NONE) begin
								res_status_q <= aocs_pkg::ST_INLIST;
							end else begin
								nwe_q <= 1'b1;
								nwd_q <= {aocs_pkg::FLAG_CLOSED, aocs_pkg::MEM_CLOSED, n_idx};
							end
						end
						aocs_pkg::OP_REM_OPEN: begin
							if (n_mem == aocs_pkg::MEM_OPEN) begin
								valid_q[n_idx] <= 1'b0;
								if (count_q != '0) begin
									count_q <= count_q - CW'(1);
								end
								nwe_q <= 1'b1;
								nwd_q <= {n_flags, aocs_pkg::MEM_NONE, n_idx};
							end else begin
								res_status_q <= aocs_pkg::ST_NOTFOUND;
							end
						end
						aocs_pkg::OP_REM_CLOSED: begin
							if (n_mem == aocs_pkg::MEM_CLOSED) begin
								nwe_q <= 1'b1;
								nwd_q <= {n_flags, aocs_pkg::MEM_NONE, n_idx};
							end else begin
								res_status_q <= aocs_pkg::ST_NOTFOUND;
							end
						end
						aocs_pkg::OP_FIND_OPEN: begin
							if (n_mem == aocs_pkg::MEM_OPEN) begin
								state_q <= S_SRD;
							end else begin
								res_status_q <= aocs_pkg::ST_NOTFOUND;
							end
						end
						aocs_pkg::OP_FIND_CLOSED: begin
							if (n_mem == aocs_pkg::MEM_CLOSED) begin
								res_found_q <= 1'b1;
								res_node_q  <= id_q;
							end else begin
								res_status_q <= aocs_pkg::ST_NOTFOUND;
							end
						end
						default: begin
							res_status_q <= aocs_pkg::ST_NOTFOUND;
						end
					endcase
				end
				S_FREE: begin
					if (valid_q[scan_q]) begin
						scan_q <= scan_q + SW'(1);
					end else begin
						valid_q[scan_q] <= 1'b1;
						swe_q   <= 1'b1;
						swa_q   <= scan_q;
						swd_q   <= {age_q, cost_q, id_q};
						nwe_q   <= 1'b1;
						nwd_q   <= {aocs_pkg::FLAG_OPEN, aocs_pkg::MEM_OPEN, scan_q};
						age_q   <= age_q + AW'(1);
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SRD: begin
					res_found_q <= 1'b1;
					res_node_q  <= id_q;
					res_fit_q   <= srd_q[IW+KW-1:IW];
					state_q     <= S_DONE;
				end
				S_SCAN: begin
					en_s1   <= 1'b1;
					sv_s1   <= valid_q[scan_q];
					sidx_s1 <= scan_q;
					scan_q  <= scan_q + SW'(1);
					if (scan_q == SW'(OPEN_SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_POPRD;
				end
				S_POPRD: begin
					if (best.have) begin
						valid_q[best_idx] <= 1'b0;
						if (count_q != '0) begin
							count_q <= count_q - CW'(1);
						end
						res_found_q <= 1'b1;
						res_node_q  <= best.node;
						res_fit_q   <= best.cost;
						state_q     <= S_POPWR;
					end else begin
						res_status_q <= aocs_pkg::ST_NOTFOUND;
						state_q      <= S_DONE;
					end
				end
				S_POPWR: begin
					nwe_q   <= 1'b1;
					nwa_q   <= NW'(best.node);
					nwd_q   <= {n_flags, aocs_pkg::MEM_NONE, n_idx};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= res_found_q;
						out_node_q   <= res_node_q;
						out_fit_q    <= res_fit_q;
						clr_pend_q   <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {1'b0, out_fit_q, out_node_q, out_status_q};

endmodule

// ===== src/aocs_check.sv =====
`timescale 1ns / 1ps
// aocs_check: port-level checks on the result channel of the store.
// Bound to astar_open_closed_store_unit; no package dependency.
module aocs_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[2:0] == 3'd0)
		else $error("found with bad status");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[46:3] == 44'd0)
		else $error("payload on empty result");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4 && m_tdata[47] == 1'b0)
		else $error("status out of range");

endmodule

bind astar_open_closed_store_unit aocs_check u_aocs_check (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for astar_open_closed_store_unit, open/closed store.
// Depends on aocs_pkg and the unit; predicts each result from its own model.
module tb;
	import aocs_pkg::*;

	localparam int SLOTS = OPEN_SLOTS_DEF;
	localparam int NODES = NODE_COUNT_DEF;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [11:0] node;
		logic [31:0] cost;
	} answer_t;

	int fails = 0;

	task automatic report(input string what, input answer_t got, input answer_t want);
		fails++;
		$display("MISMATCH %s: got st=%0d f=%0b n=%0d c=%h, want st=%0d f=%0b n=%0d c=%h",
			what, got.status, got.found, got.node, got.cost,
			want.status, want.found, want.node, want.cost);
	endtask

	class store_board;
		bit          valid [SLOTS];
		logic [11:0] snode [SLOTS];
		logic [31:0] scost [SLOTS];
		logic [31:0] sage  [SLOTS];
		logic [1:0]  flags [NODES];
		logic [1:0]  member [NODES];
		int          sidx  [NODES];
		logic [31:0] age_ctr;
		int          count;
		answer_t     pending [$];
		int          nres;

		function void clear_all();
			foreach (valid[i]) valid[i] = 0;
			foreach (flags[i]) begin
				flags[i] = FLAG_NONE;
				member[i] = MEM_NONE;
			end
			age_ctr = 0;
			count = 0;
		endfunction

		function void note_request(opcode_t op, logic [11:0] id, logic [31:0] c);
			answer_t a;
			int best;
			logic [31:0] d;
			a = '0;
			best = -1;
			case (op)
				OP_POP: begin
					for (int s = 0; s < SLOTS; s++) if (valid[s]) begin
						d = sage[s] - sage[best < 0 ? 0 : best];
						if (best < 0 || scost[s] < scost[best] ||
							(scost[s] == scost[best] && d != 0 && !d[31])) best = s;
					end
					if (best >= 0) begin
						a.found = 1; a.node = snode[best]; a.cost = scost[best];
						valid[best] = 0; member[snode[best]] = MEM_NONE; count--;
					end else a.status = ST_NOTFOUND;
				end
				OP_CLEAR: clear_all();
				OP_ADD_OPEN: begin
					if (flags[id][0]) a.status = ST_IGNORED;
					else if (member[id] != MEM_NONE) a.status = ST_INLIST;
					else if (count >= SLOTS) a.status = ST_FULL;
					else begin
						for (int s = SLOTS - 1; s >= 0; s--) if (!valid[s]) best = s;
						valid[best] = 1; snode[best] = id; scost[best] = c;
						sage[best] = age_ctr; age_ctr++; count++;
						sidx[id] = best; member[id] = MEM_OPEN; flags[id] = FLAG_OPEN;
					end
				end
				OP_ADD_CLOSED: begin
					if (member[id] != MEM_NONE) a.status = ST_INLIST;
					else begin
						member[id] = MEM_CLOSED; flags[id] = FLAG_CLOSED;
					end
				end
				OP_REM_OPEN: begin
					if (member[id] == MEM_OPEN) begin
						valid[sidx[id]] = 0; member[id] = MEM_NONE; count--;
					end else a.status = ST_NOTFOUND;
				end
				OP_REM_CLOSED: begin
					if (member[id] == MEM_CLOSED) member[id] = MEM_NONE;
					else a.status = ST_NOTFOUND;
				end
				OP_FIND_OPEN: begin
					if (member[id] == MEM_OPEN) begin
						a.found = 1; a.node = id; a.cost = scost[sidx[id]];
					end else a.status = ST_NOTFOUND;
				end
				default: begin
					if (member[id] == MEM_CLOSED) begin
						a.found = 1; a.node = id;
					end else a.status = ST_NOTFOUND;
				end
			endcase
			pending.push_back(a);
		endfunction

		task check_result(answer_t got);
			answer_t want;
			nres++;
			if (pending.size() == 0) begin
				report("unexpected result", got, '0);
				return;
			end
			want = pending.pop_front();
			if (got.status != want.status) report("status", got, want);
			else if (got.found != want.found) report("found", got, want);
			else if (got.node != want.node) report("node_out", got, want);
			else if (got.cost != want.cost) report("fitness_out", got, want);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // [11:0] node_id, [43:12] fitness_in
	logic [2:0]  s_tuser = '0;   // [2:0] opcode
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;        // [2:0] status, [14:3] node_out, [46:15] fitness_out
	logic        m_tuser;        // [0] found

	store_board board = new();
	int  idle_pct = 37;
	int  hold_off = 0;
	int  nreq = 0;

	always #5 clk = ~clk;

	astar_open_closed_store_unit uut (.*);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result({m_tdata[2:0], m_tuser, m_tdata[14:3], m_tdata[46:15]});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// s_tvalid stays up after an accepted request; the next request or an
	// idle cycle replaces it at the same edge
	task automatic send(input opcode_t op, input logic [11:0] id, input logic [31:0] c);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {4'b0, c, id};
		do @(posedge clk); while (!s_tready);
		board.note_request(op, id, c);
		nreq++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [11:0] pick_id();
		return ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(63));
	endfunction

	initial begin
		board.clear_all();
		board.nres = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, every opcode, each special case
		send(OP_POP, 0, 0);
		send(OP_FIND_OPEN, 12'hFFF, 0);
		send(OP_ADD_OPEN, 12'hFFF, 32'hFFFF_FFFF);
		send(OP_ADD_OPEN, 0, 32'h0);
		send(OP_ADD_OPEN, 1, 32'h0);
		send(OP_ADD_OPEN, 12'hFFF, 5);
		send(OP_ADD_CLOSED, 0, 0);
		send(OP_ADD_CLOSED, 7, 0);
		send(OP_ADD_OPEN, 7, 3);
		send(OP_FIND_CLOSED, 7, 0);
		send(OP_FIND_OPEN, 12'hFFF, 0);
		send(OP_POP, 0, 0);
		send(OP_POP, 0, 0);
		send(OP_REM_OPEN, 12'hFFF, 0);
		send(OP_REM_OPEN, 12'hFFF, 0);
		send(OP_REM_CLOSED, 7, 0);
		send(OP_REM_CLOSED, 7, 0);
		send(OP_ADD_OPEN, 0, 9);
		send(OP_CLEAR, 0, 0);
		send(OP_ADD_OPEN, 0, 9);
		send(OP_FIND_OPEN, 0, 0);
		drain();
		// fill the open table to overflow
		idle_pct = 0;
		for (int i = 0; i <= SLOTS; i++) send(OP_ADD_OPEN, 12'(100 + i), $urandom_range(15));
		send(OP_ADD_OPEN, 12'd99, 1);
		// long receiver hold-off while requests keep coming
		hold_off = 1500;
		for (int i = 0; i < 20; i++) send(OP_POP, 0, 0);
		drain();
		send(OP_CLEAR, 0, 0);
		idle_pct = 37;
		// random: add/find/remove mixes with frequent pops and rare clears
		for (int i = 0; i < 450; i++) begin
			int r;
			r = $urandom_range(99);
			if (i == 150) idle_pct = 0;
			if (i == 250) idle_pct = 37;
			if (r < 35) send(OP_ADD_OPEN, pick_id(), ($urandom_range(1)) ?
				$urandom : 32'($urandom_range(7)));
			else if (r < 45) send(OP_ADD_CLOSED, pick_id(), $urandom);
			else if (r < 52) send(OP_REM_OPEN, pick_id(), $urandom);
			else if (r < 58) send(OP_REM_CLOSED, pick_id(), $urandom);
			else if (r < 80) send(OP_POP, pick_id(), $urandom);
			else if (r < 89) send(OP_FIND_OPEN, pick_id(), $urandom);
			else if (r < 98) send(OP_FIND_CLOSED, pick_id(), $urandom);
			else send(OP_CLEAR, pick_id(), $urandom);
			if (i == 320) drain();
		end
		drain();
		$display("Covered %0d requests, %0d results: all opcodes, full table, long stall.",
			nreq, board.nres);
		if (fails == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
